// File: rtl/core/wpl_pkg.sv
// Shared constants, types and helpers for the wheel pulse line parser.
package wpl_pkg;

    localparam int LINE_MAX   = 32;
    localparam int CNT_W      = $clog2(LINE_MAX);
    localparam int CNT_W_HEAD = 3;
    localparam int HEAD_LEN   = 6;
    localparam int MIN_LINE   = 9;
    localparam int PULSE_W    = 16;
    localparam int SCALE_W    = 24;
    localparam int PROD_W     = PULSE_W + SCALE_W;
    localparam int FRAC_SHIFT = 8;
    localparam int RPM_W      = 32;
    localparam int COUNT_W    = 32;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] PH_LEAD   = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam logic [1:0] MK_IDLE  = 2'd0;
    localparam logic [1:0] MK_COMMA = 2'd1;
    localparam logic [1:0] MK_L     = 2'd2;
    localparam logic [1:0] MK_FOUND = 2'd3;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_GOOD = 2'd1;
    localparam logic [1:0] EV_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [PULSE_W-1:0] right_count;
        logic [PULSE_W-1:0] left_count;
    } wpl_line_t;

    // "WPS,R,"
    function automatic logic [7:0] head_char(input logic [CNT_W_HEAD-1:0] pos);
        logic [7:0] ch;
        begin
            unique case (pos)
                3'd0:    ch = 8'h57;
                3'd1:    ch = 8'h50;
                3'd2:    ch = 8'h53;
                3'd3:    ch = 8'h2C;
                3'd4:    ch = 8'h52;
                3'd5:    ch = 8'h2C;
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

// File: rtl/core/wpl_rx_if.sv
// Byte input channel.
interface wpl_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_data;

    modport source (output valid, output rx_data, input ready);
    modport sink (input valid, input rx_data, output ready);
endinterface

// File: rtl/core/wpl_res_if.sv
// Result channel.
interface wpl_res_if;
    logic                         valid;
    logic                         ready;
    logic [wpl_pkg::RPM_W-1:0]    rpm_right;
    logic [wpl_pkg::RPM_W-1:0]    rpm_left;
    logic [wpl_pkg::COUNT_W-1:0]  good_lines;
    logic [wpl_pkg::COUNT_W-1:0]  bad_lines;
    logic [1:0]                   line_event;

    modport source (output valid, output rpm_right, output rpm_left, output good_lines,
                    output bad_lines, output line_event, input ready);
    modport sink (input valid, input rpm_right, input rpm_left, input good_lines,
                  input bad_lines, input line_event, output ready);
endinterface

// File: rtl/core/wpl_number.sv
// Decimal number reader: whitespace, optional sign, digits, wraps mod 2^16.
module wpl_number (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic                         clear,
    input  logic [7:0]                   ch,
    output logic [wpl_pkg::PULSE_W-1:0]  pulses
);

    logic [1:0]                  phase_reg, phase_next;
    logic                        neg_reg, neg_next;
    logic [wpl_pkg::PULSE_W-1:0] val_reg, val_next;
    logic                        is_digit;
    logic                        is_space;
    logic [wpl_pkg::PULSE_W-1:0] digit;

    assign is_digit = (ch >= wpl_pkg::CH_ZERO) && (ch <= wpl_pkg::CH_NINE);
    assign is_space = (ch == wpl_pkg::CH_SPACE) || (ch == wpl_pkg::CH_TAB) ||
                      (ch == wpl_pkg::CH_VT) || (ch == wpl_pkg::CH_FF);
    assign digit    = wpl_pkg::PULSE_W'(ch - wpl_pkg::CH_ZERO);

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        val_next   = val_reg;
        if (clear)
        begin
            phase_next = wpl_pkg::PH_LEAD;
            neg_next   = 1'b0;
            val_next   = '0;
        end
        else if (step)
        begin
            unique case (phase_reg)
                wpl_pkg::PH_LEAD:
                begin
                    if (is_space)
                    begin
                        phase_next = wpl_pkg::PH_LEAD;
                    end
                    else if (ch == wpl_pkg::CH_PLUS)
                    begin
                        phase_next = wpl_pkg::PH_SIGN;
                    end
                    else if (ch == wpl_pkg::CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = wpl_pkg::PH_SIGN;
                    end
                    else if (is_digit)
                    begin
                        val_next   = digit;
                        phase_next = wpl_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = wpl_pkg::PH_DONE;
                    end
                end
                wpl_pkg::PH_SIGN:
                begin
                    if (is_digit)
                    begin
                        val_next   = digit;
                        phase_next = wpl_pkg::PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = wpl_pkg::PH_DONE;
                    end
                end
                wpl_pkg::PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        val_next = (val_reg << 3) + (val_reg << 1) + digit;
                    end
                    else
                    begin
                        phase_next = wpl_pkg::PH_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= wpl_pkg::PH_LEAD;
            neg_reg   <= 1'b0;
            val_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            val_reg   <= val_next;
        end
    end

    assign pulses = neg_reg ? wpl_pkg::PULSE_W'(16'd0 - val_reg) : val_reg;

endmodule

// File: rtl/core/wpl_line_parser.sv
// Per-byte line state: length, prefix check, marker search, both counts.
module wpl_line_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_en,
    input  logic [7:0]         ch,
    output wpl_pkg::wpl_line_t line
);

    logic [wpl_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      prefix_ok_reg, prefix_ok_next;
    logic                      ended_reg, ended_next;
    logic [1:0]                marker_reg, marker_next;
    logic                      is_term;
    logic                      line_clr;
    logic                      body_step;
    logic                      in_head;
    logic [1:0]                kind;
    logic [wpl_pkg::PULSE_W-1:0] right_count;
    logic [wpl_pkg::PULSE_W-1:0] left_count;

    assign is_term = (ch == wpl_pkg::CH_LF) || (ch == wpl_pkg::CH_CR);
    assign in_head = cnt_reg < wpl_pkg::CNT_W'(wpl_pkg::HEAD_LEN);

    always_comb
    begin
        cnt_next       = cnt_reg;
        prefix_ok_next = prefix_ok_reg;
        ended_next     = ended_reg;
        marker_next    = marker_reg;
        line_clr       = 1'b0;
        body_step      = 1'b0;
        kind           = wpl_pkg::EV_NONE;
        if (is_term)
        begin
            if (cnt_reg != '0)
            begin
                line_clr = 1'b1;
                if (prefix_ok_reg && (cnt_reg >= wpl_pkg::CNT_W'(wpl_pkg::MIN_LINE)) &&
                    (marker_reg == wpl_pkg::MK_FOUND))
                begin
                    kind = wpl_pkg::EV_GOOD;
                end
                else
                begin
                    kind = wpl_pkg::EV_BAD;
                end
            end
        end
        else if (cnt_reg >= wpl_pkg::CNT_W'(wpl_pkg::LINE_MAX - 1))
        begin
            line_clr = 1'b1;
            kind     = wpl_pkg::EV_BAD;
        end
        else
        begin
            if (!ended_reg)
            begin
                if (ch == wpl_pkg::CH_NUL)
                begin
                    if (in_head)
                    begin
                        prefix_ok_next = 1'b0;
                    end
                    ended_next = 1'b1;
                end
                else if (in_head)
                begin
                    if (ch != wpl_pkg::head_char(cnt_reg[wpl_pkg::CNT_W_HEAD-1:0]))
                    begin
                        prefix_ok_next = 1'b0;
                    end
                end
                else
                begin
                    body_step = 1'b1;
                    unique case (marker_reg)
                        wpl_pkg::MK_IDLE:
                            marker_next = (ch == wpl_pkg::CH_COMMA) ? wpl_pkg::MK_COMMA
                                                                    : wpl_pkg::MK_IDLE;
                        wpl_pkg::MK_COMMA:
                            marker_next = (ch == wpl_pkg::CH_L) ? wpl_pkg::MK_L :
                                          (ch == wpl_pkg::CH_COMMA) ? wpl_pkg::MK_COMMA
                                                                    : wpl_pkg::MK_IDLE;
                        wpl_pkg::MK_L:
                            marker_next = (ch == wpl_pkg::CH_COMMA) ? wpl_pkg::MK_FOUND
                                                                    : wpl_pkg::MK_IDLE;
                        default:
                            marker_next = marker_reg;
                    endcase
                end
            end
            cnt_next = cnt_reg + 1'b1;
        end
        if (line_clr)
        begin
            cnt_next       = '0;
            prefix_ok_next = 1'b1;
            ended_next     = 1'b0;
            marker_next    = wpl_pkg::MK_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            prefix_ok_reg <= 1'b1;
            ended_reg     <= 1'b0;
            marker_reg    <= wpl_pkg::MK_IDLE;
        end
        else if (byte_en)
        begin
            cnt_reg       <= cnt_next;
            prefix_ok_reg <= prefix_ok_next;
            ended_reg     <= ended_next;
            marker_reg    <= marker_next;
        end
    end

    wpl_number u_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (byte_en && body_step),
        .clear  (byte_en && line_clr),
        .ch     (ch),
        .pulses (right_count)
    );

    wpl_number u_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (byte_en && body_step && (marker_reg == wpl_pkg::MK_FOUND)),
        .clear  (byte_en && line_clr),
        .ch     (ch),
        .pulses (left_count)
    );

    assign line.kind        = kind;
    assign line.right_count = right_count;
    assign line.left_count  = left_count;

endmodule

// File: rtl/core/wheel_pulse_line_parser_unit.sv
// Top level: input register, line parser, rpm multiply and result register.
// A byte is held in the input register and its result is then stored in the result register.
// Throughput: one byte per cycle; rx.ready drops only while a held result waits on res.ready.
// The result register holds rpm values and line counts; both rpm products are
// computed (16x24 each) on a good line ending, between input and result registers.
// Reset (rst_n, async low) clears line state, rpm values, counts and scale_reg.
module wheel_pulse_line_parser_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [wpl_pkg::SCALE_W-1:0] cfg_wr_data,
    wpl_rx_if.sink                      rx,
    wpl_res_if.source                   res
);

    logic [wpl_pkg::SCALE_W-1:0] scale_reg;
    logic                        in_valid_reg;
    logic [7:0]                  in_data_reg;
    logic                        out_valid_reg;
    logic [wpl_pkg::RPM_W-1:0]   rpm_right_reg, rpm_right_next;
    logic [wpl_pkg::RPM_W-1:0]   rpm_left_reg, rpm_left_next;
    logic [wpl_pkg::COUNT_W-1:0] good_reg, good_next;
    logic [wpl_pkg::COUNT_W-1:0] bad_reg, bad_next;
    logic [1:0]                  event_reg;
    logic                        advance;
    wpl_pkg::wpl_line_t          line;
    logic [wpl_pkg::PROD_W-1:0]  prod_right;
    logic [wpl_pkg::PROD_W-1:0]  prod_left;

    assign advance  = in_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            scale_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_data_reg <= rx.rx_data;
        end
    end

    wpl_line_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (advance),
        .ch      (in_data_reg),
        .line    (line)
    );

    assign prod_right = wpl_pkg::PROD_W'(line.right_count) * wpl_pkg::PROD_W'(scale_reg);
    assign prod_left  = wpl_pkg::PROD_W'(line.left_count) * wpl_pkg::PROD_W'(scale_reg);

    always_comb
    begin
        rpm_right_next = rpm_right_reg;
        rpm_left_next  = rpm_left_reg;
        good_next      = good_reg;
        bad_next       = bad_reg;
        case (line.kind)
            wpl_pkg::EV_GOOD:
            begin
                rpm_right_next = prod_right[wpl_pkg::FRAC_SHIFT +: wpl_pkg::RPM_W];
                rpm_left_next  = prod_left[wpl_pkg::FRAC_SHIFT +: wpl_pkg::RPM_W];
                good_next      = good_reg + 1'b1;
            end
            wpl_pkg::EV_BAD:
            begin
                bad_next = bad_reg + 1'b1;
            end
            default:
            begin
                good_next = good_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rpm_right_reg <= '0;
            rpm_left_reg  <= '0;
            good_reg      <= '0;
            bad_reg       <= '0;
            event_reg     <= wpl_pkg::EV_NONE;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            rpm_right_reg <= rpm_right_next;
            rpm_left_reg  <= rpm_left_next;
            good_reg      <= good_next;
            bad_reg       <= bad_next;
            event_reg     <= line.kind;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.rpm_right  = rpm_right_reg;
    assign res.rpm_left   = rpm_left_reg;
    assign res.good_lines = good_reg;
    assign res.bad_lines  = bad_reg;
    assign res.line_event = event_reg;

endmodule
